### hdl/mexp_pkg.sv
package mexp_pkg;

	// port widths of the payload and configuration channels
	localparam int DATA_BITS  = 64;
	localparam int INDEX_BITS = 1;

	// configuration register indexes
	localparam logic [INDEX_BITS-1:0] REG_MODULUS  = 1'd0;
	localparam logic [INDEX_BITS-1:0] REG_EXPONENT = 1'd1;

	// sequencer states
	localparam int STATE_BITS = 3;
	localparam logic [STATE_BITS-1:0] S_IDLE = 3'd0;
	localparam logic [STATE_BITS-1:0] S_RED  = 3'd1;
	localparam logic [STATE_BITS-1:0] S_BIT  = 3'd2;
	localparam logic [STATE_BITS-1:0] S_SQR  = 3'd3;
	localparam logic [STATE_BITS-1:0] S_POST = 3'd4;
	localparam logic [STATE_BITS-1:0] S_MUL  = 3'd5;
	localparam logic [STATE_BITS-1:0] S_STEP = 3'd6;

endpackage

### hdl/mexp_modmul.sv
module mexp_modmul #(
	parameter int W = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	input  logic [W-1:0] m,
	output logic         done,
	output logic [W-1:0] result
);

	localparam int CW = $clog2(W);

	logic [W-1:0]  acc_q, a_q, b_q, m_q;
	logic [CW-1:0] cnt_q;
	logic          run_q, phase_q, done_q;

	logic [W-1:0] y, gap, sum, nxt;
	logic [W:0]   diff;
	logic         advance;

	// one modular add per cycle: phase 0 doubles, phase 1 adds a
	always_comb begin
		y    = phase_q ? a_q : acc_q;
		gap  = m_q - y;
		diff = {1'b0, acc_q} - {1'b0, gap};
		sum  = acc_q + y;
		nxt  = diff[W] ? sum : diff[W-1:0];
		advance = phase_q || !b_q[W-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			phase_q <= 1'b0;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q   <= 1'b1;
				phase_q <= 1'b0;
				cnt_q   <= CW'(W - 1);
			end else if (run_q) begin
				if (advance) begin
					phase_q <= 1'b0;
					if (cnt_q == '0) begin
						run_q  <= 1'b0;
						done_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end else begin
					phase_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= a;
			b_q   <= b;
			m_q   <= m;
		end else if (run_q) begin
			acc_q <= nxt;
			if (advance) b_q <= {b_q[W-2:0], 1'b0};
		end
	end

	assign done   = done_q;
	assign result = acc_q;

endmodule

### hdl/mexp_ctrl.sv
module mexp_ctrl #(
	parameter int W = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] modulus,
	input  logic [W-1:0] exponent,
	input  logic [W-1:0] base,
	output logic         busy,
	output logic         done,
	output logic [W-1:0] power,
	output logic         mul_start,
	output logic [W-1:0] mul_a,
	output logic [W-1:0] mul_b,
	output logic [W-1:0] mul_m,
	input  logic         mul_done,
	input  logic [W-1:0] mul_result
);

	import mexp_pkg::*;

	localparam int IW = $clog2(W);
	localparam logic [W-1:0] ONE = W'(1);

	logic [STATE_BITS-1:0] state_q;
	logic [W-1:0]          m_q, e_q, bb_q, d_q, power_q;
	logic [IW-1:0]         idx_q;
	logic                  mul_start_q, done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mul_start_q <= 1'b0;
			done_q      <= 1'b0;
			idx_q       <= '0;
		end else begin
			mul_start_q <= 1'b0;
			done_q      <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q     <= S_RED;
						mul_start_q <= 1'b1;
					end
				end
				S_RED: begin
					if (mul_done) begin
						idx_q   <= IW'(W - 1);
						state_q <= S_BIT;
					end
				end
				S_BIT: begin
					// squaring one gives one: skip it
					if (d_q != ONE) begin
						state_q     <= S_SQR;
						mul_start_q <= 1'b1;
					end else begin
						state_q <= S_POST;
					end
				end
				S_SQR: begin
					if (mul_done) state_q <= S_POST;
				end
				S_POST: begin
					if (e_q[idx_q]) begin
						state_q     <= S_MUL;
						mul_start_q <= 1'b1;
					end else begin
						state_q <= S_STEP;
					end
				end
				S_MUL: begin
					if (mul_done) state_q <= S_STEP;
				end
				S_STEP: begin
					if (idx_q == '0) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						idx_q   <= idx_q - 1'b1;
						state_q <= S_BIT;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			m_q  <= modulus;
			e_q  <= exponent;
			bb_q <= base;
		end
		if (state_q == S_RED && mul_done) begin
			bb_q <= mul_result;
			d_q  <= ONE;
		end
		if ((state_q == S_SQR || state_q == S_MUL) && mul_done) d_q <= mul_result;
		if (state_q == S_STEP && idx_q == '0) power_q <= d_q;
	end

	// reduction runs as 1 * base, i.e. Horner over the base bits mod m
	always_comb begin
		mul_m = m_q;
		case (state_q)
			S_RED: begin
				mul_a = ONE;
				mul_b = bb_q;
			end
			S_MUL: begin
				mul_a = d_q;
				mul_b = bb_q;
			end
			default: begin
				mul_a = d_q;
				mul_b = d_q;
			end
		endcase
	end

	assign mul_start = mul_start_q;
	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign power     = power_q;

endmodule

### hdl/modular_exponentiation.sv
// Modular exponentiation: power = base ^ exponent mod modulus.
//
// Configuration: wr_en / wr_index / wr_data write a register at the clock
// edge (index 0 modulus, index 1 exponent). Values are cut to OPERAND_BITS;
// a modulus write of 0 or 1 is dropped. Write only while busy is low.
// Input: a beat is taken at a rising edge with start high and busy low.
// busy stays high until the result beat has been produced.
// Output: power is valid for one cycle while done is high; the receiver
// cannot stall, so the result must be captured in that cycle.
// Operation: left-to-right square-and-multiply over all OPERAND_BITS exponent
// bits, one modular multiply after another on a single bit-serial unit.
// That unit does one modular add per cycle, doubling for each of the W
// multiplier bits and adding a for each set one (W = OPERAND_BITS).
// An item costs a reduction multiply, up to W squarings (skipped whenever the
// running value is one) and one multiply per set exponent bit. Each
// multiply is opened by a start pulse and closed by a done pulse, and each
// exponent bit passes the sequencer states BIT, POST and STEP. The result
// beat comes in the same cycle that busy falls low again.
// Reset: modulus 2, exponent 1, block idle, no result pending.
module modular_exponentiation #(
	parameter int OPERAND_BITS = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [mexp_pkg::INDEX_BITS-1:0]   wr_index,
	input  logic [mexp_pkg::DATA_BITS-1:0]    wr_data,
	input  logic                              start,
	input  logic [mexp_pkg::DATA_BITS-1:0]    base,
	output logic                              busy,
	output logic                              done,
	output logic [mexp_pkg::DATA_BITS-1:0]    power
);

	import mexp_pkg::*;

	localparam int W = OPERAND_BITS;

	// config registers, held at operand width
	logic [W-1:0] modulus_q, exponent_q;
	logic [W-1:0] wr_val;

	assign wr_val = wr_data[W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q  <= W'(2);
			exponent_q <= W'(1);
		end else if (wr_en) begin
			unique case (wr_index)
				REG_MODULUS: begin
					// modulus below two is ignored
					if (|wr_val[W-1:1]) modulus_q <= wr_val;
				end
				REG_EXPONENT: exponent_q <= wr_val;
				default: ;
			endcase
		end
	end

	// sequencer <-> shared multiplier
	logic         mul_start, mul_done;
	logic [W-1:0] mul_a, mul_b, mul_m, mul_result;
	logic [W-1:0] power_w;

	mexp_ctrl #(.W(W)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.modulus    (modulus_q),
		.exponent   (exponent_q),
		.base       (base[W-1:0]),
		.busy       (busy),
		.done       (done),
		.power      (power_w),
		.mul_start  (mul_start),
		.mul_a      (mul_a),
		.mul_b      (mul_b),
		.mul_m      (mul_m),
		.mul_done   (mul_done),
		.mul_result (mul_result)
	);

	mexp_modmul #(.W(W)) u_modmul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.m      (mul_m),
		.done   (mul_done),
		.result (mul_result)
	);

	// zero-extend the result to the port width
	assign power = DATA_BITS'(power_w);

endmodule

### bench/tb_modular_exponentiation.sv
`timescale 1ns / 100ps

module tb_modular_exponentiation;

	import mexp_pkg::*;

	localparam int OPERAND_BITS = 64;
	localparam logic [DATA_BITS-1:0] OPERAND_MASK = {DATA_BITS{1'b1}} >> (DATA_BITS - OPERAND_BITS);
	localparam logic [DATA_BITS-1:0] ALL_ONES = {DATA_BITS{1'b1}};
	localparam logic [DATA_BITS-1:0] TOP_BIT = {1'b1, {(DATA_BITS-1){1'b0}}};
	// cycles left to settle after the last result; a spurious done would show here
	localparam int TAIL_CYCLES = 64;

	logic                  clk;
	logic                  arst_n;
	logic                  wr_en;
	logic [INDEX_BITS-1:0] wr_index;
	logic [DATA_BITS-1:0]  wr_data;
	logic                  start;
	logic [DATA_BITS-1:0]  base;
	logic                  busy;
	logic                  done;
	logic [DATA_BITS-1:0]  power;

	// shadow copy of the configuration registers, updated on each write the block takes
	logic [DATA_BITS-1:0] cfg_modulus;
	logic [DATA_BITS-1:0] cfg_exponent;

	// predicted power for every accepted base, oldest first
	logic [DATA_BITS-1:0] pending_power_q[$];

	int fail_count;
	int bases_sent;
	int powers_checked;
	int settings_used;
	bit idle_on;

	modular_exponentiation #(
		.OPERAND_BITS(OPERAND_BITS)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_index(wr_index),
		.wr_data (wr_data),
		.start   (start),
		.base    (base),
		.busy    (busy),
		.done    (done),
		.power   (power)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Left-to-right square-and-multiply on 128-bit intermediates: every
	// product of two residues fits, so a plain % gives the exact residue.
	// Squaring while the running value is one is harmless, so all
	// OPERAND_BITS exponent bits are walked.
	function automatic logic [DATA_BITS-1:0] modexp_of(input logic [DATA_BITS-1:0] b);
		logic [127:0] m_wide;
		logic [127:0] b_red;
		logic [127:0] acc;
		m_wide = {64'd0, cfg_modulus};
		b_red = {64'd0, b & OPERAND_MASK} % m_wide;
		acc = 128'd1;
		for (int i = OPERAND_BITS - 1; i >= 0; i--) begin
			acc = (acc * acc) % m_wide;
			if (cfg_exponent[i])
				acc = (acc * b_red) % m_wide;
		end
		return acc[DATA_BITS-1:0];
	endfunction

	function automatic logic [DATA_BITS-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// append one prediction at the tail of the pending list
	task automatic enqueue_power(input logic [DATA_BITS-1:0] p);
		pending_power_q.insert(pending_power_q.size(), p);
	endtask

	task automatic report_mismatch(input string what, input logic [DATA_BITS-1:0] got,
			input logic [DATA_BITS-1:0] want);
		$display("MISMATCH @%0t: %s got 0x%016h want 0x%016h", $time, what, got, want);
		fail_count++;
	endtask

	// Result beats: done marks one cycle and cannot be stalled, so every
	// rising edge with done high is a beat. Inputs and outputs both change
	// only on NBAs at the edge, so sampling here sees the pre-edge values.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_power_q.size() == 0) begin
				report_mismatch("result with no base pending, power", power, '0);
			end else begin
				if (power !== pending_power_q[0])
					report_mismatch("power", power, pending_power_q[0]);
				void'(pending_power_q.pop_front());
				powers_checked++;
			end
		end
	end

	// Lower start, then hold until every prediction has been matched and the
	// block reports idle. Only then may the registers change.
	task automatic wait_idle();
		start <= 1'b0;
		while (pending_power_q.size() != 0 || busy)
			@(posedge clk);
	endtask

	// One register write; the trailing edge keeps wr_en from being lowered
	// and raised again in the same time step by back-to-back writes.
	task automatic write_reg(input logic [INDEX_BITS-1:0] idx, input logic [DATA_BITS-1:0] data);
		wait_idle();
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
		wr_en <= 1'b0;
		@(posedge clk);
		// a modulus below two is dropped by the block
		if (idx == REG_MODULUS) begin
			if ((data & OPERAND_MASK) >= 2)
				cfg_modulus = data & OPERAND_MASK;
		end else if (idx == REG_EXPONENT) begin
			cfg_exponent = data & OPERAND_MASK;
		end
	endtask

	task automatic set_config(input logic [DATA_BITS-1:0] m, input logic [DATA_BITS-1:0] e);
		write_reg(REG_MODULUS, m);
		write_reg(REG_EXPONENT, e);
		settings_used++;
	endtask

	// Send one base beat. start is left high on return so the next beat can
	// follow with no gap; an idle burst lowers it first.
	task automatic send_base(input logic [DATA_BITS-1:0] b);
		int gap;
		gap = 0;
		if (idle_on && $urandom_range(0, 2) == 0)
			gap = $urandom_range(1, 5);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		base <= b;
		do
			@(posedge clk);
		while (busy);
		// accepted at this edge; registers cannot change while it runs
		enqueue_power(modexp_of(b));
		bases_sent++;
	endtask

	// Reset values: modulus 2, exponent 1, so power is the low bit of base.
	task automatic test_reset_defaults();
		send_base(64'd0);
		send_base(64'd1);
		send_base(64'd2);
		send_base(64'd3);
		send_base(ALL_ONES);
	endtask

	// Modulus writes of 0 or 1 must leave the modulus alone; exponent zero
	// yields 1 even for base 0.
	task automatic test_modulus_guard_and_zero_exp();
		write_reg(REG_MODULUS, 64'd0);
		write_reg(REG_EXPONENT, 64'd3);
		send_base(64'd5);
		set_config(64'd1000, 64'd7);
		write_reg(REG_MODULUS, 64'd1);
		send_base(64'd123);
		write_reg(REG_EXPONENT, 64'd0);
		send_base(64'd0);
		send_base(ALL_ONES);
	endtask

	// Widest operands: all-ones modulus and exponent, top-bit-only values.
	task automatic test_operand_extremes();
		set_config(ALL_ONES, ALL_ONES);
		send_base(64'd0);
		send_base(64'd1);
		send_base(ALL_ONES);
		send_base(ALL_ONES - 64'd1);
		set_config(64'd2, ALL_ONES);
		send_base(ALL_ONES);
		set_config(TOP_BIT, TOP_BIT);
		send_base(64'd3);
		set_config(ALL_ONES, 64'd2);
		send_base(TOP_BIT | 64'd12345);
	endtask

	// Bases at and above the modulus are reduced before use.
	task automatic test_base_reduction();
		set_config(64'd97, 64'd5);
		send_base(64'd96);
		send_base(64'd97);
		send_base(64'd98);
		send_base(64'd194);
		send_base(ALL_ONES);
	endtask

	// Random settings, each followed by a batch of random bases. The last
	// batch runs back to back with no idle cycles.
	task automatic test_random_settings();
		logic [DATA_BITS-1:0] m;
		logic [DATA_BITS-1:0] e;
		int n;
		for (int phase = 0; phase < 9; phase++) begin
			case ($urandom_range(0, 4))
				0: m = DATA_BITS'($urandom_range(2, 1000));
				1: m = ALL_ONES;
				2: m = rand64() | TOP_BIT;
				default: m = rand64() >> $urandom_range(0, 62);
			endcase
			if (m < 2)
				m = 2;
			case ($urandom_range(0, 5))
				0: e = 64'd0;
				1: e = DATA_BITS'($urandom_range(1, 20));
				2: e = ALL_ONES;
				default: e = rand64() >> $urandom_range(0, 63);
			endcase
			set_config(m, e);
			if ($urandom_range(0, 3) == 0)
				write_reg(REG_MODULUS, DATA_BITS'($urandom_range(0, 1)));
			if (phase == 8) begin
				idle_on = 1'b0;
				n = 20;
			end else begin
				n = $urandom_range(8, 12);
			end
			repeat (n) begin
				case ($urandom_range(0, 7))
					0: send_base(64'd0);
					1: send_base(64'd1);
					2: send_base(cfg_modulus - 64'd1);
					3: send_base(cfg_modulus);
					4: send_base(ALL_ONES);
					5: send_base(rand64() >> $urandom_range(0, 63));
					default: send_base(rand64());
				endcase
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		start = 1'b0;
		base = '0;
		cfg_modulus = 64'd2;
		cfg_exponent = 64'd1;
		fail_count = 0;
		bases_sent = 0;
		powers_checked = 0;
		settings_used = 1;
		idle_on = 1'b1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_modulus_guard_and_zero_exp();
		test_operand_extremes();
		test_base_reduction();
		test_random_settings();

		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Coverage: %0d bases over %0d register settings, %0d powers checked",
			bases_sent, settings_used, powers_checked);
		if (fail_count == 0 && pending_power_q.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("%0d mismatches, %0d powers never produced", fail_count,
				pending_power_q.size());
			$display("Some tests failed");
		end
		$finish;
	end

	// timeout guard against a hang, set well above the worst-case run time
	initial begin
		#150_000_000;
		$display("Timeout with %0d powers outstanding", pending_power_q.size());
		$display("Some tests failed");
		$finish;
	end

endmodule
